### rtl/core/pbrle_pkg.sv
// ----------------------------------------------------------------------------
// pbrle_pkg
// Shared types and constants of the PackBits run-length encoder.
// ----------------------------------------------------------------------------
package pbrle_pkg;

  // undecided bytes held ahead of a packet decision
  localparam int unsigned LaDepth = 3;
  // code bytes carried by one output beat
  localparam int unsigned OutLanes = 4;

  // byte push / end-of-step flush from sequencer to packer
  typedef struct packed {
    logic       push;
    logic [7:0] data;
    logic       flush;
    logic       last;
  } pk_req_t;

endpackage

### rtl/core/pbrle_ram.sv
// ----------------------------------------------------------------------------
// pbrle_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pbrle_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/pbrle_pack.sv
// ----------------------------------------------------------------------------
// pbrle_pack
// Gathers code bytes into beats of up to Chunk bytes; output register.
// ----------------------------------------------------------------------------
module pbrle_pack #(
  parameter int unsigned Chunk = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pbrle_pkg::pk_req_t  req_i,
  output logic                rdy_o,
  output logic                m_tvalid_o,
  input  logic                m_tready_i,
  output logic [39:0]         m_tdata_o,
  output logic                m_tuser_o,
  output logic                m_tlast_o
);

  localparam int unsigned CW = $clog2(Chunk + 1);
  localparam int unsigned IW = (Chunk > 1) ? $clog2(Chunk) : 1;

  logic [7:0]    buf_q [Chunk];
  logic [CW-1:0] cnt_q, cnt_d;
  logic          ov_q;
  logic [7:0]    ob_q [pbrle_pkg::OutLanes];
  logic [7:0]    ob_d [pbrle_pkg::OutLanes];
  logic [2:0]    ocnt_q;
  logic          ostep_q, olast_q;

  logic out_free, full, empty, ld;

  assign out_free = !ov_q || m_tready_i;
  assign full     = (cnt_q == CW'(Chunk));
  assign empty    = (cnt_q == '0);
  assign rdy_o    = req_i.push ? (!full || out_free) : (empty || out_free);
  assign ld       = out_free && ((req_i.push && full) || (req_i.flush && !empty));

  // mask lanes at or beyond the fill count
  for (genvar j = 0; j < pbrle_pkg::OutLanes; j++) begin : g_lane
    if (j < Chunk) begin : g_used
      assign ob_d[j] = (CW'(j) < cnt_q) ? buf_q[j] : 8'h00;
    end else begin : g_zero
      assign ob_d[j] = 8'h00;
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (req_i.push && rdy_o) begin
      cnt_d = full ? CW'(1) : cnt_q + CW'(1);
    end else if (req_i.flush && rdy_o) begin
      cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (ld) begin
        ov_q <= 1'b1;
      end else if (m_tready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.push && rdy_o) begin
      if (full) begin
        buf_q[0] <= req_i.data;
      end else begin
        buf_q[cnt_q[IW-1:0]] <= req_i.data;
      end
    end
    if (ld) begin
      ob_q    <= ob_d;
      ocnt_q  <= 3'(cnt_q);
      ostep_q <= req_i.flush;
      olast_q <= req_i.flush && req_i.last;
    end
  end

  assign m_tvalid_o = ov_q;
  assign m_tdata_o  = {5'b0, ocnt_q, ob_q[3], ob_q[2], ob_q[1], ob_q[0]};
  assign m_tuser_o  = ostep_q;
  assign m_tlast_o  = olast_q;

endmodule

### rtl/core/packbits_rle_encoder.sv
// ----------------------------------------------------------------------------
// packbits_rle_encoder
// Streaming PackBits encoder: raw bytes in, packed code beats out.
// ----------------------------------------------------------------------------
// Input beat: one raw byte on s_tdata, s_tlast marks the last byte of a
// stream and flushes every open packet. Output beat: up to four code bytes
// in stream order plus a count; tuser marks the last beat caused by an
// input byte, tlast the last beat of the whole stream. A byte that closes
// no packet causes no beat.
// One byte is taken at a time. A byte that only extends a packet passes
// through accept, one or two decision steps, a second literal byte and
// the end-of-step flush. Sending a literal pushes the header and then each
// stored byte, as the literal store RAM is read one entry at a time; a run
// pushes its header and its value.
// A beat goes to the output register when a fifth code byte or the
// end-of-step flush arrives.
// The literal store is a RAM of MAX_PACKET entries with no clearing pass;
// only the written prefix of it is ever read.
// Reset empties lookahead, packer and output register; no packet is open.
// When the receiver stalls, the output register holds its beat and the
// sequencer waits on the packer, so no byte is dropped; s_tready stays low
// until the current byte's work is done.
// ----------------------------------------------------------------------------
module packbits_rle_encoder #(
  parameter int unsigned MAX_PACKET = 128,
  parameter int unsigned MIN_REPEAT = 3,
  parameter int unsigned OUT_BYTES  = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,   // final_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  // [7:0] code_byte_a, [15:8] code_byte_b, [23:16] code_byte_c,
  // [31:24] code_byte_d, [34:32] byte_count, rest zero
  output logic [39:0] m_tdata,
  output logic        m_tuser,   // step_done
  output logic        m_tlast    // stream_done
);

  localparam int unsigned Chunk = (OUT_BYTES < 4) ? OUT_BYTES : 4;
  localparam int unsigned AW    = $clog2(MAX_PACKET);
  localparam int unsigned LW    = $clog2(MAX_PACKET + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_TAKE2, S_LITHDR, S_LITDATA, S_RUNHDR, S_RUNVAL, S_END
  } state_e;

  typedef enum logic [1:0] {M_IDLE, M_LIT, M_RUN} mode_e;

  state_e     state_q, state_d;
  mode_e      mode_q, mode_d;
  logic [7:0] la_q [pbrle_pkg::LaDepth];
  logic [7:0] la_d [pbrle_pkg::LaDepth];
  logic [1:0] la_cnt_q, la_cnt_d;
  logic       fin_q, fin_d;
  logic [LW-1:0] lit_len_q, lit_len_d;
  logic [LW-1:0] run_len_q, run_len_d;
  logic [7:0]    run_val_q, run_val_d;
  logic [AW-1:0] idx_q, idx_d;

  // literal store port
  logic          ram_we, ram_re;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [7:0]    ram_rdata;

  pbrle_pkg::pk_req_t req;
  logic               req_rdy;

  // run detection over the lookahead
  logic eq1, eq2, is_run, take2, room2;
  logic [1:0] drop_n;

  assign eq1    = (la_cnt_q >= 2'd2) && (la_q[1] == la_q[0]);
  assign eq2    = (la_cnt_q == 2'd3) && (la_q[2] == la_q[0]);
  assign is_run = (MIN_REPEAT == 2) ? eq1 : (eq1 && eq2);
  assign take2  = eq1 && !is_run;
  assign room2  = ({1'b0, lit_len_q} + (LW + 1)'(2)) <= (LW + 1)'(MAX_PACKET);

  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    la_cnt_d  = la_cnt_q;
    fin_d     = fin_q;
    lit_len_d = lit_len_q;
    run_len_d = run_len_q;
    run_val_d = run_val_q;
    idx_d     = idx_q;
    drop_n    = 2'd0;
    ram_we    = 1'b0;
    ram_waddr = lit_len_q[AW-1:0];
    ram_re    = 1'b0;
    ram_raddr = idx_q;
    req       = '0;
    req.last  = fin_q;
    s_tready  = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          if (la_cnt_q != 2'd3) begin
            la_cnt_d = la_cnt_q + 2'd1;
          end
          fin_d   = s_tlast;
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        priority if (mode_q == M_LIT && lit_len_q >= LW'(MAX_PACKET)) begin
          state_d = S_LITHDR;
        end else if (la_cnt_q == 2'd0) begin
          state_d = S_END;
        end else if (mode_q == M_RUN) begin
          if (la_q[0] == run_val_q && run_len_q < LW'(MAX_PACKET)) begin
            run_len_d = run_len_q + LW'(1);
            drop_n    = 2'd1;
          end else begin
            state_d = S_RUNHDR;
          end
        end else if (la_cnt_q < 2'(MIN_REPEAT) && !fin_q) begin
          state_d = S_END;
        end else if (mode_q == M_IDLE) begin
          if (is_run) begin
            run_val_d = la_q[0];
            run_len_d = LW'(MIN_REPEAT);
            drop_n    = 2'(MIN_REPEAT);
            mode_d    = M_RUN;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = '0;
            lit_len_d = LW'(1);
            drop_n    = 2'd1;
            mode_d    = M_LIT;
            if (take2) begin
              state_d = S_TAKE2;
            end
          end
        end else begin
          if (is_run) begin
            state_d = S_LITHDR;
          end else begin
            ram_we    = 1'b1;
            lit_len_d = lit_len_q + LW'(1);
            drop_n    = 2'd1;
            if (take2 && room2) begin
              state_d = S_TAKE2;
            end
          end
        end
      end
      S_TAKE2: begin
        ram_we    = 1'b1;
        lit_len_d = lit_len_q + LW'(1);
        drop_n    = 2'd1;
        state_d   = S_DECIDE;
      end
      S_LITHDR: begin
        req.push = 1'b1;
        req.data = 8'(lit_len_q - LW'(1));
        if (req_rdy) begin
          ram_re    = 1'b1;
          ram_raddr = '0;
          idx_d     = '0;
          state_d   = S_LITDATA;
        end
      end
      S_LITDATA: begin
        req.push = 1'b1;
        req.data = ram_rdata;
        if (req_rdy) begin
          if (LW'(idx_q) == lit_len_q - LW'(1)) begin
            lit_len_d = '0;
            mode_d    = M_IDLE;
            state_d   = S_DECIDE;
          end else begin
            idx_d     = idx_q + AW'(1);
            ram_re    = 1'b1;
            ram_raddr = idx_q + AW'(1);
          end
        end
      end
      S_RUNHDR: begin
        req.push = 1'b1;
        req.data = 8'(9'd257 - 9'(run_len_q));
        if (req_rdy) begin
          state_d = S_RUNVAL;
        end
      end
      S_RUNVAL: begin
        req.push = 1'b1;
        req.data = run_val_q;
        if (req_rdy) begin
          run_len_d = '0;
          mode_d    = M_IDLE;
          state_d   = S_DECIDE;
        end
      end
      S_END: begin
        priority if (fin_q && mode_q == M_LIT) begin
          state_d = S_LITHDR;
        end else if (fin_q && mode_q == M_RUN) begin
          state_d = S_RUNHDR;
        end else begin
          req.flush = 1'b1;
          if (req_rdy) begin
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (drop_n != 2'd0) begin
      la_cnt_d = la_cnt_q - drop_n;
    end
  end

  // lookahead shift / fill
  always_comb begin
    la_d = la_q;
    if (state_q == S_IDLE && s_tvalid && la_cnt_q != 2'd3) begin
      la_d[la_cnt_q] = s_tdata;
    end
    unique case (drop_n)
      2'd1: begin
        la_d[0] = la_q[1];
        la_d[1] = la_q[2];
      end
      2'd2: la_d[0] = la_q[2];
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      mode_q    <= M_IDLE;
      la_cnt_q  <= '0;
      fin_q     <= 1'b0;
      lit_len_q <= '0;
      run_len_q <= '0;
      run_val_q <= '0;
      idx_q     <= '0;
    end else begin
      state_q   <= state_d;
      mode_q    <= mode_d;
      la_cnt_q  <= la_cnt_d;
      fin_q     <= fin_d;
      lit_len_q <= lit_len_d;
      run_len_q <= run_len_d;
      run_val_q <= run_val_d;
      idx_q     <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    la_q <= la_d;
  end

  pbrle_ram #(
    .Width (8),
    .Depth (MAX_PACKET)
  ) u_lit_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (la_q[0]),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  pbrle_pack #(
    .Chunk (Chunk)
  ) u_pack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req),
    .rdy_o      (req_rdy),
    .m_tvalid_o (m_tvalid),
    .m_tready_i (m_tready),
    .m_tdata_o  (m_tdata),
    .m_tuser_o  (m_tuser),
    .m_tlast_o  (m_tlast)
  );

  // beats carry 1..Chunk bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid |-> (m_tdata[34:32] != 3'd0 && m_tdata[34:32] <= 3'(Chunk)))
    else $error("byte count out of range");

  // end of stream is always end of a step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_tvalid && m_tlast) |-> m_tuser)
    else $error("stream end without step end");

  // open literal never exceeds the store, nor an open run MAX_PACKET
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    lit_len_q <= LW'(MAX_PACKET) && run_len_q <= LW'(MAX_PACKET))
    else $error("packet length overflow");

  // a new byte is taken only with room in the lookahead
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid && s_tready) |-> (la_cnt_q < 2'(MIN_REPEAT)))
    else $error("lookahead overfull at accept");

endmodule

### dv/tb_packbits_rle_encoder.sv
// ----------------------------------------------------------------------------
// tb_packbits_rle_encoder
// Self-checking bench for the PackBits encoder: a byte-level model of the
// coder predicts every output beat, and a monitor compares each beat that
// is taken against the oldest prediction. Directed cases are followed by
// random streams of runs, literals and noise, with bursty input and a
// stalling receiver.
// ----------------------------------------------------------------------------
module tb_packbits_rle_encoder;

  localparam int unsigned MaxPkt  = 128;
  localparam int unsigned MinRep  = 3;
  localparam int unsigned Lanes   = 4;
  localparam int unsigned IdleLim = 20000;

  typedef enum logic [1:0] {
    CoderIdle = 2'd0,
    CoderLit  = 2'd1,
    CoderRun  = 2'd2
  } coder_e;

  typedef struct packed {
    logic [7:0] b3;
    logic [7:0] b2;
    logic [7:0] b1;
    logic [7:0] b0;
    logic [2:0] cnt;
    logic       step_end;
    logic       strm_end;
  } beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  packbits_rle_encoder i_dut (
    .clk_i, .rst_ni,
    .s_tvalid, .s_tready, .s_tdata, .s_tlast,
    .m_tvalid, .m_tready, .m_tdata, .m_tuser, .m_tlast
  );

  always #10 clk_i = ~clk_i;

  // coder shadow state
  logic [7:0]  lit_buf [MaxPkt];
  int unsigned lit_len;
  logic [7:0]  ahead [3];
  int unsigned ahead_cnt;
  logic [7:0]  rep_val;
  int unsigned rep_len;
  coder_e      mode;
  logic [7:0]  code_q [$];   // code bytes of the current step
  beat_t       pending_beats [$];

  int unsigned errors;
  int unsigned idle_cycles;
  bit          hold_rx;      // receiver forced off during the fill test

  task automatic report(input string what, input beat_t got, input beat_t exp);
    $display("ERROR t=%0t %s got=%h exp=%h", $realtime, what, got, exp);
    errors++;
  endtask

  function automatic void put_code(logic [7:0] b);
    code_q = {code_q, b};
  endfunction

  function automatic void emit_literal();
    if (lit_len > 0) begin
      put_code(8'(lit_len - 1));
      for (int i = 0; i < lit_len; i++) put_code(lit_buf[i]);
    end
    lit_len = 0;
    mode = CoderIdle;
  endfunction

  function automatic void emit_run();
    put_code(8'(257 - rep_len));
    put_code(rep_val);
    rep_len = 0;
    mode = CoderIdle;
  endfunction

  function automatic void shift_ahead(int unsigned n);
    if (n > ahead_cnt) n = ahead_cnt;
    for (int i = 0; i + n < ahead_cnt; i++) ahead[i] = ahead[i + n];
    ahead_cnt -= n;
  endfunction

  function automatic void grow_literal(int unsigned n);
    for (int i = 0; i < n && i < ahead_cnt; i++)
      if (lit_len < MaxPkt) begin
        lit_buf[lit_len] = ahead[i];
        lit_len++;
      end
    shift_ahead(n);
  endfunction

  // predict the beats caused by one input byte
  function automatic void encode_byte(logic [7:0] din, logic fin);
    int unsigned k, room, pos, n;
    beat_t bt;
    code_q.delete();
    if (ahead_cnt < 3) begin
      ahead[ahead_cnt] = din;
      ahead_cnt++;
    end
    forever begin
      if (mode == CoderLit && lit_len >= MaxPkt) begin
        emit_literal();
        continue;
      end
      if (ahead_cnt == 0) break;
      if (mode == CoderRun) begin
        if (ahead[0] == rep_val && rep_len < MaxPkt) begin
          rep_len++;
          shift_ahead(1);
        end else begin
          emit_run();
        end
        continue;
      end
      if (ahead_cnt < MinRep && !fin) break;
      k = 1;
      while (k < ahead_cnt && k < MinRep && ahead[k] == ahead[0]) k++;
      if (mode == CoderIdle) begin
        if (k >= MinRep) begin
          rep_val = ahead[0];
          rep_len = k;
          shift_ahead(k);
          mode = CoderRun;
        end else begin
          lit_len = 0;
          grow_literal(k);
          mode = CoderLit;
        end
      end else if (k >= MinRep) begin
        emit_literal();
      end else begin
        room = MaxPkt - lit_len;
        grow_literal(k < room ? k : room);
      end
    end
    if (fin) begin
      if (mode == CoderLit) emit_literal();
      else if (mode == CoderRun) emit_run();
      mode = CoderIdle;
    end
    pos = 0;
    while (pos < code_q.size()) begin
      n = code_q.size() - pos;
      if (n > Lanes) n = Lanes;
      bt = '0;
      bt.b0 = code_q[pos];
      if (n > 1) bt.b1 = code_q[pos + 1];
      if (n > 2) bt.b2 = code_q[pos + 2];
      if (n > 3) bt.b3 = code_q[pos + 3];
      bt.cnt = 3'(n);
      bt.step_end = (pos + n == code_q.size());
      bt.strm_end = bt.step_end && fin;
      pending_beats = {pending_beats, bt};
      pos += n;
    end
  endfunction

  // send one byte; prediction is made when the beat is taken
  task automatic send_byte(input logic [7:0] d, input logic fin);
    s_tvalid <= 1'b1;
    s_tdata  <= d;
    s_tlast  <= fin;
    do @(posedge clk_i); while (!s_tready);
    encode_byte(d, fin);
  endtask

  // bursty sender: drop valid for a random gap once a burst is used up
  int unsigned burst_left;
  task automatic send_paced(input logic [7:0] d, input logic fin);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    send_byte(d, fin);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_run_of(input logic [7:0] v, input int unsigned n, input bit fin_last);
    for (int i = 0; i < n; i++) send_paced(v, fin_last && (i == n - 1));
  endtask

  task automatic send_literal_of(input int unsigned n, input bit fin_last);
    logic [7:0] v;
    for (int i = 0; i < n; i++) begin
      v = 8'(i * 37 + 5);
      send_paced(v, fin_last && (i == n - 1));
    end
  endtask

  // short streams, extremes, a literal closed by a run
  task automatic test_directed();
    send_byte(8'h00, 1'b1);                 // single byte stream
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b1);                 // short stream end, pair
    send_run_of(8'hA5, 3, 1'b1);            // minimal run
    send_literal_of(5, 1'b0);
    send_run_of(8'hC3, 4, 1'b0);            // literal closed by a run
    send_byte(8'h80, 1'b1);
    drain();
  endtask

  // receiver held off while the sender keeps offering bytes; the literal
  // fills up, and the pair that would overshoot it is split
  task automatic test_backpressure();
    hold_rx = 1'b1;
    fork
      begin
        int unsigned c = 0;
        while (c < 1000) begin
          @(posedge clk_i);
          c++;
        end
        hold_rx = 1'b0;
      end
      begin
        send_literal_of(MaxPkt - 1, 1'b0);
        send_byte(8'h77, 1'b0);
        send_byte(8'h77, 1'b0);
        send_byte(8'h12, 1'b1);
      end
    join
    drain();                                // sender waits for every beat
  endtask

  task automatic test_random(input int unsigned n_items);
    int unsigned sent = 0;
    int unsigned len, kind;
    logic [7:0] v;
    while (sent < n_items) begin
      kind = $urandom_range(0, 9);
      if (kind < 4) begin
        len = $urandom_range(2, 8);
        v = 8'($urandom);
        send_run_of(v, len, 1'b0);
      end else if (kind < 8) begin
        len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++) send_paced(8'($urandom_range(0, 3)), 1'b0);
      end else begin
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++) send_paced(8'($urandom), 1'b0);
      end
      sent += len;
      if ($urandom_range(0, 5) == 0) begin
        send_paced(8'($urandom), 1'b1);
        sent++;
      end
    end
    send_paced(8'($urandom), 1'b1);
    drain();
  endtask

  // receiver stall pattern
  always @(posedge clk_i) begin
    if (hold_rx) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(0, 99) < 70) || ($urandom_range(0, 7) == 0);
  end

  // output checker
  always @(posedge clk_i) begin
    beat_t got, exp;
    if (rst_ni && m_tvalid && m_tready) begin
      got = {m_tdata[31:0], m_tdata[34:32], m_tuser, m_tlast};
      if (pending_beats.size() == 0) begin
        report("unexpected beat", got, '0);
      end else begin
        exp = pending_beats.pop_front();
        if (got.cnt != exp.cnt) report("byte_count", got, exp);
        if (got.b0 != exp.b0) report("code_byte_a", got, exp);
        if (got.b1 != exp.b1) report("code_byte_b", got, exp);
        if (got.b2 != exp.b2) report("code_byte_c", got, exp);
        if (got.b3 != exp.b3) report("code_byte_d", got, exp);
        if (got.step_end != exp.step_end) report("step_done", got, exp);
        if (got.strm_end != exp.strm_end) report("stream_done", got, exp);
        if (m_tdata[39:35] != '0) report("tdata pad", got, exp);
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLim) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    errors = 0;
    idle_cycles = 0;
    hold_rx = 1'b0;
    burst_left = 0;
    lit_len = 0;
    ahead_cnt = 0;
    rep_val = '0;
    rep_len = 0;
    mode = CoderIdle;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_backpressure();
    test_random(64);
    repeat (200) @(posedge clk_i);
    if (errors == 0 && pending_beats.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
